FILE: src/ifhg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_pkg
// types, codes and constants shared by the fragment header generator
// ----------------------------------------------------------------------------
package ifhg_pkg;

    localparam logic [15:0] MTU_FLOOR = 16'd1084;
    localparam logic [15:0] MTU_RESET = 16'd1500;

    localparam int DF_POS = 14;
    localparam int MF_POS = 13;
    localparam int OFF_W  = 13;

    // depth of the command queue between classifier and sequencer
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] STATUS_FITS    = 2'd0;
    localparam logic [1:0] STATUS_FRAG    = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    typedef struct packed {
        logic [15:0] total_length;
        logic [3:0]  header_words;
        logic [15:0] frag_field;
        logic [15:0] rest_sum;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frag_field_out;
        logic [15:0] total_length_out;
        logic [15:0] checksum_out;
        logic [15:0] payload_start;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

    // classified work for the sequencer
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] field;
        logic [15:0] rest;
        logic [15:0] tot;
        logic [15:0] payload;
        logic [15:0] chunk;
        logic [15:0] full_len;
    } t_cmd;

    function automatic logic [15:0] hdr_checksum(
        input logic [15:0] rest,
        input logic [15:0] len,
        input logic [15:0] field
    );
        logic [17:0] s0;
        logic [16:0] s1;
        logic [15:0] s2;
        s0 = {2'b00, rest} + {2'b00, len} + {2'b00, field};
        s1 = {1'b0, s0[15:0]} + {15'd0, s0[17:16]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

endpackage
`default_nettype wire

FILE: src/ifhg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_front
// classifies a header: fits, refused or fragmented, and sizes the fragments
// ----------------------------------------------------------------------------
module ifhg_front (
    input  wire ifhg_pkg::t_item i_item,
    input  wire [15:0]           i_mtu,
    output ifhg_pkg::t_cmd       o_cmd
);
    import ifhg_pkg::*;

    logic [15:0] hlen;
    logic [15:0] chunk;

    assign hlen  = {10'd0, i_item.header_words, 2'b00};
    // usable payload per fragment, down to a multiple of 8
    assign chunk = (i_mtu - hlen) & ~16'd7;

    always_comb begin
        o_cmd.field    = i_item.frag_field;
        o_cmd.rest     = i_item.rest_sum;
        o_cmd.tot      = i_item.total_length;
        o_cmd.chunk    = chunk;
        o_cmd.full_len = hlen + chunk;
        o_cmd.payload  = (i_item.total_length >= hlen) ? (i_item.total_length - hlen)
                                                       : 16'd0;
        if (i_item.total_length <= i_mtu) begin
            o_cmd.status = STATUS_FITS;
        end else if (i_item.frag_field[DF_POS]) begin
            o_cmd.status = STATUS_REFUSED;
        end else begin
            o_cmd.status = STATUS_FRAG;
        end
    end

endmodule
`default_nettype wire

FILE: src/ifhg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_queue
// short command queue between the classifier and the fragment sequencer
// ----------------------------------------------------------------------------
module ifhg_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire ifhg_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output ifhg_pkg::t_cmd      o_data
);
    import ifhg_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(Q_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= bump(r_wp);
            end
            if (do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |=> o_full)
        else $error("full queue lost an entry without a pop");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> r_wp == r_rp)
        else $error("empty queue with pointers apart");
`endif

endmodule
`default_nettype wire

FILE: src/ifhg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifhg_back
// fragment sequencer: walks one command and, while the output is not stalled, emits one result per cycle
// ----------------------------------------------------------------------------
module ifhg_back #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_valid,
    input  wire ifhg_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ifhg_pkg::t_result   o_out_data
);
    import ifhg_pkg::*;

    localparam int NW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

    logic             r_busy;
    t_cmd             r_cmd;
    logic [15:0]      r_remain;
    logic [15:0]      r_rlen;
    logic [OFF_W-1:0] r_off;
    logic [15:0]      r_pos;
    logic [NW-1:0]    r_n;
    logic             r_out_valid;
    t_result          r_out;

    logic             can_emit;
    logic             emit;
    logic             more;
    logic             at_end;
    logic             mf;
    logic [15:0]      f_word;
    logic [15:0]      f_len;
    t_result          n_out;

    assign can_emit  = !r_out_valid || !i_out_stall;
    assign emit      = r_busy && can_emit;
    assign o_cmd_pop = !r_busy && i_cmd_valid;

    assign more   = r_remain > r_cmd.chunk;
    assign at_end = !more || (r_n == NW'(MAX_FRAGMENTS - 1));
    assign mf     = (r_n == '0) || more || r_cmd.field[MF_POS];
    assign f_word = {2'b00, mf, r_off};
    assign f_len  = more ? r_cmd.full_len : r_rlen;

    always_comb begin
        n_out = '0;
        unique case (r_cmd.status)
            STATUS_FITS: begin
                n_out.status           = STATUS_FITS;
                n_out.frag_field_out   = r_cmd.field;
                n_out.total_length_out = r_cmd.tot;
                n_out.checksum_out     = hdr_checksum(r_cmd.rest, r_cmd.tot, r_cmd.field);
                n_out.payload_length   = r_cmd.payload;
                n_out.last             = 1'b1;
            end
            STATUS_FRAG: begin
                n_out.status           = STATUS_FRAG;
                n_out.frag_field_out   = f_word;
                n_out.total_length_out = f_len;
                n_out.checksum_out     = hdr_checksum(r_cmd.rest, f_len, f_word);
                n_out.payload_start    = r_pos;
                n_out.payload_length   = more ? r_cmd.chunk : r_remain;
                n_out.last             = at_end;
            end
            default: begin
                n_out.status = STATUS_REFUSED;
                n_out.last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd    <= i_cmd;
            r_remain <= i_cmd.payload;
            r_rlen   <= i_cmd.tot;
            r_off    <= i_cmd.field[OFF_W-1:0];
            r_pos    <= '0;
            r_n      <= '0;
        end else if (emit) begin
            r_remain <= r_remain - r_cmd.chunk;
            r_rlen   <= r_rlen - r_cmd.chunk;
            r_off    <= r_off + r_cmd.chunk[15:3];
            r_pos    <= r_pos + r_cmd.chunk;
            r_n      <= r_n + NW'(1);
        end
        if (can_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_out.last) begin
                r_busy <= 1'b0;
            end
            if (can_emit) begin
                r_out_valid <= r_busy;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_single_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != STATUS_FRAG |-> r_out.last)
        else $error("pass or refused result without last");
    a_mid_has_mf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == STATUS_FRAG && !r_out.last
            |-> r_out.frag_field_out[MF_POS])
        else $error("non-final fragment without MF");
    a_frag_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cmd.status == STATUS_FRAG |-> r_remain != 16'd0)
        else $error("fragment walk with no payload left");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && n_out.last |=> !r_busy || $past(o_cmd_pop))
        else $error("sequencer busy after final result");
`endif

endmodule
`default_nettype wire

FILE: src/ipv4_fragment_header_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator
// per-fragment IPv4 header fields for a datagram on a link of given MTU
// ----------------------------------------------------------------------------
// usage
//   input channel: one header description per transfer (valid/stall).
//   output channel: one result per fragment, last marks the final one of a
//   datagram; a fitting datagram gives one pass result, a DF datagram that
//   does not fit gives one refused result.
//   config channel: writes link_mtu (valid/ready, always ready); values
//   below 1084 are stored as 1084. write only while the block is idle.
// timing
//   a classified header waits in a two-entry queue; the sequencer loads it
//   once idle, then emits one result per cycle while the output is not
//   stalled, up to MAX_FRAGMENTS results per datagram. a result passes
//   through the queue, the command register and the output register.
// reset
//   synchronous, active low; queue and output empty, link_mtu = 1500.
// stall
//   the output register holds its result while stalled; the sequencer
//   halts, and the input stalls once the queue is full.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire ifhg_pkg::t_item  i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output ifhg_pkg::t_result     o_out_data,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [15:0]            i_cfg_data
);
    import ifhg_pkg::*;

    logic [15:0] r_mtu;
    t_cmd        front_cmd;
    t_cmd        q_cmd;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        in_push;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_push     = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu <= MTU_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mtu <= (i_cfg_data < MTU_FLOOR) ? MTU_FLOOR : i_cfg_data;
        end
    end

    ifhg_front u_front (
        .i_item (i_in_data),
        .i_mtu  (r_mtu),
        .o_cmd  (front_cmd)
    );

    ifhg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    ifhg_back #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
